### src/gibs_pkg.sv
// Shared types and constants for the greedy IoU box suppression block.
package gibs_pkg;

	// Number of register stages in the overlap test unit.
	localparam int IOU_STAGES = 4;

	// Width of the confidence score and of the threshold.
	localparam int SCORE_BITS = 16;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SEEK = 3'b010,
		S_PASS = 3'b100
	} state_t;

	// Per-cell controls: insert a new box, rotate the ring, drop the entry.
	typedef struct packed {
		logic load;
		logic rotate;
		logic kill;
	} ctl_t;

endpackage

### src/gibs_cell.sv
// One cell of the box chain: sorted insertion while loading, a ring slot while suppressing.
module gibs_cell #(
	parameter int CB = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gibs_pkg::ctl_t                        ctl,
	input  logic [gibs_pkg::SCORE_BITS+4*CB:0]    new_entry,
	input  logic [gibs_pkg::SCORE_BITS+4*CB:0]    up_entry,
	input  logic                                  up_gt,
	input  logic [gibs_pkg::SCORE_BITS+4*CB:0]    dn_entry,
	output logic [gibs_pkg::SCORE_BITS+4*CB:0]    entry,
	output logic                                  gt
);
	localparam int EW = gibs_pkg::SCORE_BITS + 4 * CB + 1;

	logic          valid_q;
	logic [EW-2:0] data_q;

	assign entry = {valid_q, data_q};

	// The new box belongs ahead of this entry when it scores strictly higher or the cell is empty.
	assign gt = !valid_q ||
		(new_entry[EW-2 -: gibs_pkg::SCORE_BITS] > data_q[EW-2 -: gibs_pkg::SCORE_BITS]);

	// Valid bit: cleared by reset and by a pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.kill) begin
			valid_q <= 1'b0;
		end else if (ctl.rotate) begin
			valid_q <= dn_entry[EW-1];
		end else if (ctl.load) begin
			if (up_gt) begin
				valid_q <= up_entry[EW-1];
			end else if (gt) begin
				valid_q <= new_entry[EW-1];
			end
		end
	end

	// Box payload follows the same moves.
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			data_q <= dn_entry[EW-2:0];
		end else if (ctl.load) begin
			if (up_gt) begin
				data_q <= up_entry[EW-2:0];
			end else if (gt) begin
				data_q <= new_entry[EW-2:0];
			end
		end
	end

endmodule

### src/gibs_iou.sv
// Pipelined overlap test of a ring entry against the anchor box, written back to the ring tail.
module gibs_iou #(
	parameter int CB = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  chk,
	input  logic [gibs_pkg::SCORE_BITS+4*CB:0]    in_entry,
	input  logic [CB-1:0]                         ax1,
	input  logic [CB-1:0]                         ay1,
	input  logic [CB-1:0]                         ax2,
	input  logic [CB-1:0]                         ay2,
	input  logic [gibs_pkg::SCORE_BITS-1:0]       thr,
	output logic [gibs_pkg::SCORE_BITS+4*CB:0]    out_entry,
	output logic                                  hit
);
	localparam int EW = gibs_pkg::SCORE_BITS + 4 * CB + 1;
	localparam int AW = 2 * CB;
	localparam int PW = AW + 1 + gibs_pkg::SCORE_BITS;

	logic [CB-1:0] bx1, by1, bx2, by2;
	logic [CB-1:0] hx, lx, hy, ly, dx, dy, bw, bh, aw, ah;

	logic          v_s1, c_s1, v_s2, c_s2, v_s3, c_s3, v_s4, c_s4;
	logic [EW-2:0] e_s1, e_s2, e_s3, e_s4;
	logic [CB-1:0] dx_s1, dy_s1, bw_s1, bh_s1, aw_s1, ah_s1;
	logic [AW-1:0] inter_s2, ab_s2, aa_s2, inter_s3, inter_s4;
	logic [AW:0]   total, uni_s3;
	logic          zero_s3, zero_s4;
	logic [PW-1:0] prod_s4;
	logic          over;

	assign bx1 = in_entry[4*CB-1 -: CB];
	assign by1 = in_entry[3*CB-1 -: CB];
	assign bx2 = in_entry[2*CB-1 -: CB];
	assign by2 = in_entry[CB-1:0];

	// Intersection spans and side lengths.
	always_comb begin
		hx = (ax2 < bx2) ? ax2 : bx2;
		lx = (ax1 > bx1) ? ax1 : bx1;
		hy = (ay2 < by2) ? ay2 : by2;
		ly = (ay1 > by1) ? ay1 : by1;
		dx = (hx > lx) ? hx - lx : '0;
		dy = (hy > ly) ? hy - ly : '0;
		bw = (bx2 > bx1) ? bx2 - bx1 : bx1 - bx2;
		bh = (by2 > by1) ? by2 - by1 : by1 - by2;
		aw = (ax2 > ax1) ? ax2 - ax1 : ax1 - ax2;
		ah = (ay2 > ay1) ? ay2 - ay1 : ay1 - ay2;
	end

	assign total = {1'b0, aa_s2} + {1'b0, ab_s2};

	// Stage control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			c_s1 <= 1'b0;
			v_s2 <= 1'b0;
			c_s2 <= 1'b0;
			v_s3 <= 1'b0;
			c_s3 <= 1'b0;
			v_s4 <= 1'b0;
			c_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_entry[EW-1];
			c_s1 <= chk;
			v_s2 <= v_s1;
			c_s2 <= c_s1;
			v_s3 <= v_s2;
			c_s3 <= c_s2;
			v_s4 <= v_s3;
			c_s4 <= c_s3;
		end
	end

	// Stage datapath: spans, then areas, then union, then threshold product.
	always_ff @(posedge clk) begin
		if (en) begin
			e_s1     <= in_entry[EW-2:0];
			dx_s1    <= dx;
			dy_s1    <= dy;
			bw_s1    <= bw;
			bh_s1    <= bh;
			aw_s1    <= aw;
			ah_s1    <= ah;
			e_s2     <= e_s1;
			inter_s2 <= dx_s1 * dy_s1;
			ab_s2    <= bw_s1 * bh_s1;
			aa_s2    <= aw_s1 * ah_s1;
			e_s3     <= e_s2;
			inter_s3 <= inter_s2;
			zero_s3  <= total <= {1'b0, inter_s2};
			uni_s3   <= total - {1'b0, inter_s2};
			e_s4     <= e_s3;
			inter_s4 <= inter_s3;
			zero_s4  <= zero_s3;
			prod_s4  <= PW'(thr) * PW'(uni_s3);
		end
	end

	// Suppress when inter scaled by 2^16 exceeds threshold times union.
	assign over = !zero_s4 &&
		({1'b0, inter_s4, {gibs_pkg::SCORE_BITS{1'b0}}} > prod_s4);
	assign hit = v_s4 && c_s4 && over;
	assign out_entry = {v_s4 && !(c_s4 && over), e_s4};

endmodule

### src/greedy_iou_box_suppression.sv
// Greedy non-maximum suppression by IoU over a chain of box cells.
//
// Boxes are offered on left_x, top_y, right_x, bottom_y, score and final_box with a
// start pulse; a beat is taken at an edge where start is high and busy is low. While
// loading, one beat is taken every cycle and the box is inserted in score order (ties
// keep arrival order) into the cell chain in that same cycle. Boxes beyond MAX_BOXES are
// dropped and overflowed is reported on every result of that set. A beat with final_box
// raises busy and starts suppression. The chain then runs as a ring of MAX_BOXES + 4
// slots through a four stage overlap unit: the head kept box is popped and the ring
// turns twice, the first turn testing every entry against it and the second letting the
// last overlap results settle and bringing the ring back into order. Empty slots
// between kept boxes are skipped by turning the ring. Each kept box appears for one
// cycle with kept_valid high, in score order, the last one with end_of_set; busy falls
// as that beat appears. The receiver cannot stall. cfg_we writes the IoU threshold
// (unsigned Q0.16); the user must write it only while idle, as the block does not
// enforce this. Reset empties the chain and sets the threshold to 0.5.
module greedy_iou_box_suppression #(
	parameter int MAX_BOXES  = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gibs_pkg::SCORE_BITS-1:0]     cfg_wdata,
	input  logic                                start,
	output logic                                busy,
	input  logic [COORD_BITS-1:0]               left_x,
	input  logic [COORD_BITS-1:0]               top_y,
	input  logic [COORD_BITS-1:0]               right_x,
	input  logic [COORD_BITS-1:0]               bottom_y,
	input  logic [gibs_pkg::SCORE_BITS-1:0]     score,
	input  logic                                final_box,
	output logic                                kept_valid,
	output logic [COORD_BITS-1:0]               kept_left_x,
	output logic [COORD_BITS-1:0]               kept_top_y,
	output logic [COORD_BITS-1:0]               kept_right_x,
	output logic [COORD_BITS-1:0]               kept_bottom_y,
	output logic                                end_of_set,
	output logic                                overflowed
);
	localparam int CB    = COORD_BITS;
	localparam int EW    = gibs_pkg::SCORE_BITS + 4 * CB + 1;
	localparam int CW    = $clog2(MAX_BOXES + 1);
	localparam int RING  = MAX_BOXES + gibs_pkg::IOU_STAGES;
	localparam int LAST  = 2 * RING - 1;
	localparam int PCW   = $clog2(LAST + 1);

	gibs_pkg::state_t state_q;
	logic [CW-1:0]    loaded_q, rem_q, rem_next;
	logic [PCW-1:0]   cnt_q;
	logic             ovf_q, set_ovf_q;
	logic [gibs_pkg::SCORE_BITS-1:0] thr_q;
	logic [CB-1:0]    ax1_q, ay1_q, ax2_q, ay2_q;

	logic             accept, load_en, rotate, pop, chk, hit, pass_end;
	logic [EW-1:0]    new_entry, tail_entry;
	logic [EW-1:0]    cell_e  [MAX_BOXES];
	logic             cell_gt [MAX_BOXES];

	assign busy      = state_q != gibs_pkg::S_IDLE;
	assign accept    = start && !busy;
	assign load_en   = accept && (loaded_q < CW'(MAX_BOXES));
	assign new_entry = {1'b1, score, left_x, top_y, right_x, bottom_y};

	// Sequencer decisions.
	assign pop      = (state_q == gibs_pkg::S_SEEK) && cell_e[0][EW-1];
	assign rotate   = ((state_q == gibs_pkg::S_SEEK) && !cell_e[0][EW-1]) ||
		(state_q == gibs_pkg::S_PASS);
	assign chk      = (state_q == gibs_pkg::S_PASS) && (cnt_q < PCW'(RING));
	assign pass_end = (state_q == gibs_pkg::S_PASS) && (cnt_q == PCW'(LAST));

	always_comb begin
		rem_next = rem_q;
		if (pop) begin
			rem_next = rem_q - CW'(1);
		end else if (hit) begin
			rem_next = rem_q - CW'(1);
		end
	end

	// Chain of cells: insertion while loading, ring shift toward cell 0 while suppressing.
	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		gibs_pkg::ctl_t ctl;
		logic [EW-1:0]  up_e, dn_e;
		logic           up_g;

		assign ctl.load   = load_en;
		assign ctl.rotate = rotate;
		assign ctl.kill   = (i == 0) ? pop : 1'b0;
		assign up_e = (i == 0) ? '0 : cell_e[(i == 0) ? 0 : i - 1];
		assign up_g = (i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1];
		assign dn_e = (i == MAX_BOXES - 1) ? tail_entry :
			cell_e[(i == MAX_BOXES - 1) ? i : i + 1];

		gibs_cell #(.CB(CB)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_entry (new_entry),
			.up_entry  (up_e),
			.up_gt     (up_g),
			.dn_entry  (dn_e),
			.entry     (cell_e[i]),
			.gt        (cell_gt[i])
		);
	end

	// Overlap unit closing the ring.
	gibs_iou #(.CB(CB)) u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (rotate),
		.chk       (chk),
		.in_entry  (cell_e[0]),
		.ax1       (ax1_q),
		.ay1       (ay1_q),
		.ax2       (ax2_q),
		.ay2       (ay2_q),
		.thr       (thr_q),
		.out_entry (tail_entry),
		.hit       (hit)
	);

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= gibs_pkg::SCORE_BITS'(32768);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gibs_pkg::S_IDLE;
			loaded_q   <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			set_ovf_q  <= 1'b0;
			kept_valid <= 1'b0;
		end else begin
			kept_valid <= 1'b0;
			rem_q      <= rem_next;
			unique case (state_q)
				gibs_pkg::S_IDLE: begin
					if (accept) begin
						if (final_box) begin
							rem_q     <= loaded_q + CW'(load_en);
							loaded_q  <= '0;
							set_ovf_q <= ovf_q || !load_en;
							ovf_q     <= 1'b0;
							state_q   <= gibs_pkg::S_SEEK;
						end else begin
							loaded_q <= loaded_q + CW'(load_en);
							ovf_q    <= ovf_q || !load_en;
						end
					end
				end
				gibs_pkg::S_SEEK: begin
					if (pop) begin
						cnt_q   <= '0;
						state_q <= gibs_pkg::S_PASS;
					end
				end
				gibs_pkg::S_PASS: begin
					cnt_q <= cnt_q + PCW'(1);
					if (pass_end) begin
						kept_valid <= 1'b1;
						state_q    <= (rem_next == '0) ? gibs_pkg::S_IDLE : gibs_pkg::S_SEEK;
					end
				end
				default: begin
					state_q <= gibs_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Anchor box and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			ax1_q <= cell_e[0][4*CB-1 -: CB];
			ay1_q <= cell_e[0][3*CB-1 -: CB];
			ax2_q <= cell_e[0][2*CB-1 -: CB];
			ay2_q <= cell_e[0][CB-1:0];
		end
		if (pass_end) begin
			kept_left_x   <= ax1_q;
			kept_top_y    <= ay1_q;
			kept_right_x  <= ax2_q;
			kept_bottom_y <= ay2_q;
			end_of_set    <= rem_next == '0;
			overflowed    <= set_ovf_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_beat_after_pass: assert property (@(posedge clk) disable iff (!arst_n)
		kept_valid |-> $past(state_q == gibs_pkg::S_PASS))
		else $error("result beat without a finished pass");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gibs_pkg::S_IDLE) |-> (rem_q == '0))
		else $error("idle with boxes still pending");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CW'(MAX_BOXES))
		else $error("load count beyond capacity");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(kept_valid && end_of_set) |-> (state_q == gibs_pkg::S_IDLE))
		else $error("last beat but still busy");
	a_pop_counts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (rem_q != '0))
		else $error("pop with no boxes pending");
`endif

endmodule

### bench/greedy_iou_box_suppression_tb.sv
// Self-checking testbench for the greedy IoU box suppression block.
module greedy_iou_box_suppression_tb;

	localparam int MAX_BOXES   = 64;
	localparam int COORD_BITS  = 12;
	localparam int THR_BITS    = gibs_pkg::SCORE_BITS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int FLUSH_WAIT  = 200;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t            x1;
		coord_t            y1;
		coord_t            x2;
		coord_t            y2;
		logic [THR_BITS-1:0] conf;
	} box_rec_t;

	typedef struct {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
		logic   last;
		logic   ovf;
	} kept_rec_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [THR_BITS-1:0] cfg_wdata;
	logic                start;
	logic                busy;
	coord_t              left_x, top_y, right_x, bottom_y;
	logic [THR_BITS-1:0] score;
	logic                final_box;
	logic                kept_valid;
	coord_t              kept_left_x, kept_top_y, kept_right_x, kept_bottom_y;
	logic                end_of_set;
	logic                overflowed;

	// Predictor state: the boxes of the set being loaded and the threshold.
	box_rec_t            set_boxes[$];
	logic                set_overflow;
	logic [THR_BITS-1:0] iou_thr;
	kept_rec_t           kept_queue[$];

	int  errors;
	int  cycles;
	int  send_gap_pct;

	greedy_iou_box_suppression #(
		.MAX_BOXES (MAX_BOXES),
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.left_x       (left_x),
		.top_y        (top_y),
		.right_x      (right_x),
		.bottom_y     (bottom_y),
		.score        (score),
		.final_box    (final_box),
		.kept_valid   (kept_valid),
		.kept_left_x  (kept_left_x),
		.kept_top_y   (kept_top_y),
		.kept_right_x (kept_right_x),
		.kept_bottom_y(kept_bottom_y),
		.end_of_set   (end_of_set),
		.overflowed   (overflowed)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Intersection along one axis, zero when the spans do not meet.
	function automatic longint unsigned axis_overlap(coord_t a1, coord_t a2, coord_t b1, coord_t b2);
		coord_t hi, lo;
		hi = (a2 < b2) ? a2 : b2;
		lo = (a1 > b1) ? a1 : b1;
		return (hi > lo) ? longint'(hi - lo) : 0;
	endfunction

	function automatic longint unsigned box_area(box_rec_t b);
		longint unsigned w, h;
		w = (b.x2 > b.x1) ? b.x2 - b.x1 : b.x1 - b.x2;
		h = (b.y2 > b.y1) ? b.y2 - b.y1 : b.y1 - b.y2;
		return w * h;
	endfunction

	// Division-free IoU test; an empty union never suppresses.
	function automatic bit suppressed_by(box_rec_t a, box_rec_t b);
		longint unsigned inter, total;
		inter = axis_overlap(a.x1, a.x2, b.x1, b.x2) * axis_overlap(a.y1, a.y2, b.y1, b.y2);
		total = box_area(a) + box_area(b);
		if (total <= inter)
			return 1'b0;
		return (inter << 16) > longint'(iou_thr) * (total - inter);
	endfunction

	// Sort the set by descending score (stable), suppress, and queue kept boxes.
	task automatic predict_set();
		box_rec_t  ordered[$];
		box_rec_t  kept[$];
		kept_rec_t r;
		int        pos;
		bit        keep;
		foreach (set_boxes[i]) begin
			pos = ordered.size();
			while (pos > 0 && ordered[pos-1].conf < set_boxes[i].conf)
				pos--;
			ordered.insert(pos, set_boxes[i]);
		end
		foreach (ordered[i]) begin
			keep = 1'b1;
			foreach (kept[k])
				if (suppressed_by(ordered[i], kept[k]))
					keep = 1'b0;
			if (keep)
				kept.insert(kept.size(), ordered[i]);
		end
		foreach (kept[i]) begin
			r.x1   = kept[i].x1;
			r.y1   = kept[i].y1;
			r.x2   = kept[i].x2;
			r.y2   = kept[i].y2;
			r.last = (i == kept.size() - 1);
			r.ovf  = set_overflow;
			kept_queue.insert(kept_queue.size(), r);
		end
		set_boxes.delete();
		set_overflow = 1'b0;
	endtask

	// Send one box; wait for acceptance, then update the predictor.
	// Start stays high after the beat until the next idle cycle or drain lowers it.
	task automatic send_box(box_rec_t b, bit last);
		box_rec_t st;
		if (send_gap_pct > 0)
			while ($urandom_range(99) < send_gap_pct) begin
				start <= 1'b0;
				@(negedge clk);
			end
		start     <= 1'b1;
		left_x    <= b.x1;
		top_y     <= b.y1;
		right_x   <= b.x2;
		bottom_y  <= b.y2;
		score     <= b.conf;
		final_box <= last;
		do
			@(posedge clk);
		while (busy);
		st = b;
		if (set_boxes.size() < MAX_BOXES)
			set_boxes.insert(set_boxes.size(), st);
		else
			set_overflow = 1'b1;
		if (last)
			predict_set();
		@(negedge clk);
	endtask

	// Compare each kept-box beat with the oldest expectation.
	always @(posedge clk) begin
		kept_rec_t e;
		if (arst_n && kept_valid) begin
			if (kept_queue.size() == 0) begin
				$error("unexpected kept box beat");
				errors++;
			end else begin
				e = kept_queue.pop_front();
				if (kept_left_x !== e.x1) begin
					$error("kept_left_x exp %0d got %0d", e.x1, kept_left_x); errors++;
				end
				if (kept_top_y !== e.y1) begin
					$error("kept_top_y exp %0d got %0d", e.y1, kept_top_y); errors++;
				end
				if (kept_right_x !== e.x2) begin
					$error("kept_right_x exp %0d got %0d", e.x2, kept_right_x); errors++;
				end
				if (kept_bottom_y !== e.y2) begin
					$error("kept_bottom_y exp %0d got %0d", e.y2, kept_bottom_y); errors++;
				end
				if (end_of_set !== e.last) begin
					$error("end_of_set exp %0d got %0d", e.last, end_of_set); errors++;
				end
				if (overflowed !== e.ovf) begin
					$error("overflowed exp %0d got %0d", e.ovf, overflowed); errors++;
				end
			end
		end
	end

	// Wait until every kept box of the sets sent so far has come out.
	task automatic drain();
		start <= 1'b0;
		while (kept_queue.size() > 0)
			@(negedge clk);
		repeat (FLUSH_WAIT) @(negedge clk);
	endtask

	task automatic write_threshold(logic [THR_BITS-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		iou_thr = v;
	endtask

	function automatic box_rec_t rand_box(int span_max);
		box_rec_t b;
		b.x1   = coord_t'($urandom_range(4095));
		b.y1   = coord_t'($urandom_range(4095));
		b.x2   = coord_t'((b.x1 + $urandom_range(span_max)) % 4096);
		b.y2   = coord_t'((b.y1 + $urandom_range(span_max)) % 4096);
		if ($urandom_range(3) == 0) begin
			b.x2 = coord_t'($urandom_range(4095));
			b.y2 = coord_t'($urandom_range(4095));
		end
		b.conf = ($urandom_range(3) == 0) ? THR_BITS'($urandom_range(3) * 21845) :
			THR_BITS'($urandom_range(65535));
		return b;
	endfunction

	// Clustered boxes around one spot so that suppression really happens.
	task automatic send_cluster_set(int count);
		box_rec_t b;
		int       cx, cy;
		cx = $urandom_range(3800);
		cy = $urandom_range(3800);
		for (int i = 0; i < count; i++) begin
			b.x1   = coord_t'(cx + $urandom_range(40));
			b.y1   = coord_t'(cy + $urandom_range(40));
			b.x2   = coord_t'(b.x1 + $urandom_range(250));
			b.y2   = coord_t'(b.y1 + $urandom_range(250));
			b.conf = ($urandom_range(4) == 0) ? 16'h8000 : THR_BITS'($urandom_range(65535));
			if ($urandom_range(9) == 0)
				b = rand_box(4095);
			send_box(b, i == count - 1);
		end
	endtask

	// Extremes: corner values, degenerate and inverted boxes, equal scores.
	task automatic test_directed();
		box_rec_t b;
		b = '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF};
		send_box(b, 1'b0);
		b = '{12'd0, 12'd0, 12'd4095, 12'd4095, 16'hFFFF};
		send_box(b, 1'b0);
		b = '{12'd4095, 12'd4095, 12'd0, 12'd0, 16'h0000};
		send_box(b, 1'b0);
		b = '{12'd100, 12'd100, 12'd100, 12'd100, 16'h1234};
		send_box(b, 1'b0);
		b = '{12'd100, 12'd100, 12'd100, 12'd100, 16'h1234};
		send_box(b, 1'b0);
		b = '{12'd10, 12'd10, 12'd20, 12'd20, 16'h5555};
		send_box(b, 1'b0);
		b = '{12'd12, 12'd10, 12'd22, 12'd20, 16'hAAAA};
		send_box(b, 1'b1);
		// A lone box is its own set.
		b = '{12'hAAA, 12'h555, 12'h555, 12'hAAA, 16'h0001};
		send_box(b, 1'b1);
		// Zero-union pair: both points stay.
		b = '{12'd7, 12'd7, 12'd7, 12'd7, 16'd9};
		send_box(b, 1'b0);
		send_box(b, 1'b1);
	endtask

	// Fill past capacity, with the final box itself dropped.
	task automatic test_overflow();
		for (int i = 0; i < MAX_BOXES + 3; i++)
			send_box(rand_box(300), i == MAX_BOXES + 2);
	endtask

	// Random sets, mostly clustered, with mixed sizes.
	task automatic test_random(int item_goal);
		int sent;
		int n;
		sent = 0;
		while (sent < item_goal) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(10, 1);
			if ($urandom_range(3) == 0) begin
				for (int i = 0; i < n; i++)
					send_box(rand_box(($urandom_range(1)) ? 4095 : 200), i == n - 1);
			end else
				send_cluster_set(n);
			sent += n;
		end
	endtask

	initial begin
		errors       = 0;
		cycles       = 0;
		iou_thr      = 16'd32768;
		set_overflow = 1'b0;
		send_gap_pct = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		start        = 1'b0;
		left_x       = '0;
		top_y        = '0;
		right_x      = '0;
		bottom_y     = '0;
		score        = '0;
		final_box    = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_threshold(16'd0);
		test_directed();
		write_threshold(16'hFFFF);
		test_directed();
		test_overflow();
		write_threshold(16'd32768);

		send_gap_pct = 0;
		test_random(90);
		write_threshold(16'd19661);
		send_gap_pct = 58;
		test_random(90);
		write_threshold(16'd45875);
		send_gap_pct = 25;
		test_random(80);
		write_threshold(16'd0);
		send_gap_pct = 58;
		test_random(35);
		write_threshold(16'hFFFF);
		send_gap_pct = 0;
		test_random(35);

		drain();
		if (errors == 0 && kept_queue.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
src/gibs_pkg.sv
src/gibs_cell.sv
src/gibs_iou.sv
src/greedy_iou_box_suppression.sv
bench/greedy_iou_box_suppression_tb.sv
